// File: hdl/fspla_pkg.sv
// ----------------------------------------------------------------------------
// fspla_pkg
// Shared types and constants for the four-state PLA evaluator.
// ----------------------------------------------------------------------------
package fspla_pkg;

    // Array geometry: input columns and output rows.
    localparam int NUM_INPUTS  = 16;
    localparam int NUM_OUTPUTS = 16;

    // Fixed widths of the stream fields.
    localparam int FIELD_W   = 16;
    localparam int ROW_FLD_W = 4;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 2;

    // Row index width inside the personality store.
    localparam int ROW_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

    // Columns at or above NUM_INPUTS never take part in a reduction.
    localparam logic [FIELD_W-1:0] COL_MASK =
        (NUM_INPUTS >= FIELD_W) ? {FIELD_W{1'b1}}
                                : FIELD_W'((64'd1 << NUM_INPUTS) - 64'd1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOGIC_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FORMAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ASYNC_MODE   = 2'd2;

    // Reduction kinds.
    localparam logic [1:0] KIND_AND  = 2'd0;
    localparam logic [1:0] KIND_OR   = 2'd1;
    localparam logic [1:0] KIND_NAND = 2'd2;
    localparam logic [1:0] KIND_NOR  = 2'd3;

    // Item operations carried in tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Configuration as seen by the row reducer.
    typedef struct packed {
        logic [1:0] logic_kind;
        logic       plane_format;
        logic       async_mode;
    } cfg_t;

    // One four-state scalar: value and unknown bit.
    typedef struct packed {
        logic aval;
        logic bval;
    } logic4_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DONE
    } fsm_t;

endpackage

// File: hdl/fspla_row_reduce.sv
// ----------------------------------------------------------------------------
// fspla_row_reduce
// Reduces one personality row against the input vector to one four-state bit.
// ----------------------------------------------------------------------------
module fspla_row_reduce (
    input  fspla_pkg::cfg_t                       cfg,
    input  logic [fspla_pkg::FIELD_W-1:0]         row_aval,
    input  logic [fspla_pkg::FIELD_W-1:0]         row_bval,
    input  logic [fspla_pkg::FIELD_W-1:0]         in_aval,
    input  logic [fspla_pkg::FIELD_W-1:0]         in_bval,
    output fspla_pkg::logic4_t                    res
);
    import fspla_pkg::*;

    logic [FIELD_W-1:0] in_one;
    logic [FIELD_W-1:0] in_zero;
    logic [FIELD_W-1:0] term_one;
    logic [FIELD_W-1:0] term_zero;
    logic [FIELD_W-1:0] sel;
    logic               is_and;
    logic               invert;
    logic               red_one;
    logic               red_zero;

    // Known input levels per column; unknown and high impedance are neither.
    assign in_one  = in_aval & ~in_bval;
    assign in_zero = ~in_aval & ~in_bval;

    // Column selection and the resulting term per column.
    always_comb
    begin
        if (cfg.plane_format)
        begin
            // Known codes pick true or complemented input, x forces unknown,
            // z drops the column.
            sel       = (~row_bval | row_aval) & COL_MASK;
            term_one  = ~row_bval & ((row_aval & in_one) | (~row_aval & in_zero));
            term_zero = ~row_bval & ((row_aval & in_zero) | (~row_aval & in_one));
        end
        else
        begin
            // Only a code of one selects the true input.
            sel       = row_aval & ~row_bval & COL_MASK;
            term_one  = in_one;
            term_zero = in_zero;
        end
    end

    assign is_and = (cfg.logic_kind == KIND_AND) || (cfg.logic_kind == KIND_NAND);
    assign invert = (cfg.logic_kind == KIND_NAND) || (cfg.logic_kind == KIND_NOR);

    // AND: any zero wins, all ones give one. OR: any one wins, all zeros give zero.
    always_comb
    begin
        if (is_and)
        begin
            red_zero = |(sel & term_zero);
            red_one  = !red_zero && ((sel & ~term_one) == '0);
        end
        else
        begin
            red_one  = |(sel & term_one);
            red_zero = !red_one && ((sel & ~term_zero) == '0);
        end
    end

    // Optional inversion and encoding; unknown is driven as x.
    always_comb
    begin
        if (red_one || red_zero)
        begin
            res.aval = red_one ^ invert;
            res.bval = 1'b0;
        end
        else
        begin
            res.aval = 1'b1;
            res.bval = 1'b1;
        end
    end

endmodule

// File: hdl/four_state_pla_evaluator_unit.sv
// ----------------------------------------------------------------------------
// four_state_pla_evaluator_unit
// Four-state PLA: row writes into a personality store and evaluations that
// reduce one row per cycle through a shared row reducer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Content
//  s_*      in         tuser: op; tdata: row, row_aval, row_bval, in_aval, in_bval
//  m_*      out        tdata: out_aval, out_bval
//  cfg_*    in         write enable, register index, write data
//
//  An evaluation reduces one row per cycle through the single row reducer,
//  then presents the result beat. A row write in async mode after the first
//  evaluation also starts a sweep; other row writes leave the block idle.
//  s_tready is low from the beat that starts a sweep until the result beat
//  leaves; a stalled m_tready holds the block in that wait.
//  Reset clears the personality store, the last inputs and all control state.
//
module four_state_pla_evaluator_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input beat.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [0] op
    input  logic                                   s_tuser,
    // [3:0] row, [19:4] row_aval, [35:20] row_bval, [51:36] in_aval,
    // [67:52] in_bval, [71:68] zero
    input  logic [fspla_pkg::S_DATA_W-1:0]         s_tdata,
    // Result beat.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [15:0] out_aval, [31:16] out_bval
    output logic [fspla_pkg::M_DATA_W-1:0]         m_tdata,
    // Configuration write port.
    input  logic                                   cfg_we,
    input  logic [fspla_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [fspla_pkg::CFG_DAT_W-1:0]        cfg_wdata
);
    import fspla_pkg::*;

    // Unpacked input fields.
    logic [ROW_FLD_W-1:0] row;
    logic [FIELD_W-1:0]   row_aval;
    logic [FIELD_W-1:0]   row_bval;
    logic [FIELD_W-1:0]   in_aval;
    logic [FIELD_W-1:0]   in_bval;

    assign row      = s_tdata[3:0];
    assign row_aval = s_tdata[19:4];
    assign row_bval = s_tdata[35:20];
    assign in_aval  = s_tdata[51:36];
    assign in_bval  = s_tdata[67:52];

    // State.
    cfg_t               cfg_reg;
    fsm_t               state_reg, state_next;
    logic [ROW_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [FIELD_W-1:0] acc_aval_reg, acc_aval_next;
    logic [FIELD_W-1:0] acc_bval_reg, acc_bval_next;
    logic [FIELD_W-1:0] last_aval_reg;
    logic [FIELD_W-1:0] last_bval_reg;
    logic               evaluated_reg;
    logic [FIELD_W-1:0] pers_aval_reg [NUM_OUTPUTS];
    logic [FIELD_W-1:0] pers_bval_reg [NUM_OUTPUTS];

    logic               s_beat;
    logic               row_ok;
    logic               wr_row;
    logic               start_eval;
    logic               last_row;
    logic [FIELD_W-1:0] cur_aval;
    logic [FIELD_W-1:0] cur_bval;
    logic4_t            row_res;

    assign s_beat     = s_tvalid && s_tready;
    assign row_ok     = (32'(row) < NUM_OUTPUTS);
    assign wr_row     = s_beat && (s_tuser == OP_WRITE) && row_ok;
    assign start_eval = s_beat && ((s_tuser == OP_EVAL) ||
                        (row_ok && cfg_reg.async_mode && evaluated_reg));
    assign last_row   = (row_cnt_reg == ROW_W'(NUM_OUTPUTS - 1));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LOGIC_KIND:   cfg_reg.logic_kind   <= cfg_wdata[1:0];
                REG_PLANE_FORMAT: cfg_reg.plane_format <= cfg_wdata[0];
                REG_ASYNC_MODE:   cfg_reg.async_mode   <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Personality store, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_OUTPUTS; i++)
            begin
                pers_aval_reg[i] <= '0;
                pers_bval_reg[i] <= '0;
            end
        end
        else if (wr_row)
        begin
            pers_aval_reg[ROW_W'(row)] <= row_aval;
            pers_bval_reg[ROW_W'(row)] <= row_bval;
        end
    end

    // Last evaluated inputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_aval_reg <= '0;
            last_bval_reg <= '0;
            evaluated_reg <= 1'b0;
        end
        else if (s_beat && (s_tuser == OP_EVAL))
        begin
            last_aval_reg <= in_aval;
            last_bval_reg <= in_bval;
            evaluated_reg <= 1'b1;
        end
    end

    // Row currently under evaluation feeds the shared reducer.
    assign cur_aval = pers_aval_reg[row_cnt_reg];
    assign cur_bval = pers_bval_reg[row_cnt_reg];

    fspla_row_reduce u_reduce (
        .cfg      (cfg_reg),
        .row_aval (cur_aval),
        .row_bval (cur_bval),
        .in_aval  (last_aval_reg),
        .in_bval  (last_bval_reg),
        .res      (row_res)
    );

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Result accumulator; row 0 ends up in the top bit after the last shift.
    always_ff @(posedge clk)
    begin
        acc_aval_reg <= acc_aval_next;
        acc_bval_reg <= acc_bval_next;
    end

    // Next state, counter, accumulator and handshake outputs.
    always_comb
    begin
        state_next    = state_reg;
        row_cnt_next  = row_cnt_reg;
        acc_aval_next = acc_aval_reg;
        acc_bval_next = acc_bval_reg;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (start_eval)
                begin
                    state_next    = ST_EVAL;
                    row_cnt_next  = '0;
                    acc_aval_next = '0;
                    acc_bval_next = '0;
                end
            end
            ST_EVAL:
            begin
                acc_aval_next = {acc_aval_reg[FIELD_W-2:0], row_res.aval};
                acc_bval_next = {acc_bval_reg[FIELD_W-2:0], row_res.bval};
                if (last_row)
                begin
                    state_next   = ST_DONE;
                    row_cnt_next = '0;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tdata = {acc_bval_reg, acc_aval_reg};

`ifndef SYNTH
    // No new beat is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready)
        else $error("input accepted while result pending");

    // A result only appears right after the last row was reduced.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_EVAL && last_row))
        else $error("result without a full row sweep");

    // An evaluate beat always starts a sweep from row zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && s_tuser == OP_EVAL) |=> (state_reg == ST_EVAL && row_cnt_reg == '0))
        else $error("evaluation did not start");

    // The row counter stays idle at zero outside a sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EVAL) |-> (row_cnt_reg == '0))
        else $error("row counter not parked");
`endif

endmodule

// File: sim/four_state_pla_evaluator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_state_pla_evaluator_unit_test
// Self-checking bench for the four-state PLA evaluator. Personality rows and
// evaluations are streamed in with random gaps while the result side stalls
// at random. An in-bench model of the array computes every expected output
// term, and each result beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module four_state_pla_evaluator_unit_test;

    import fspla_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 10;
    localparam int MAX_IDLE     = 14;
    localparam int SETTLE       = 24;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 95;
    localparam int RAND_PHASES  = 12;

    // One input item as the sender sees it.
    typedef struct packed {
        logic                 op;
        logic [ROW_FLD_W-1:0] row;
        logic [FIELD_W-1:0]   row_aval;
        logic [FIELD_W-1:0]   row_bval;
        logic [FIELD_W-1:0]   in_aval;
        logic [FIELD_W-1:0]   in_bval;
    } pla_item_t;

    // One output term vector, laid out as on m_tdata (aval in the low half).
    typedef struct packed {
        logic [FIELD_W-1:0] bval;
        logic [FIELD_W-1:0] aval;
    } pla_out_t;

    // Reduced four-state level; z folds into unknown.
    typedef enum logic [1:0] {
        LV_0,
        LV_1,
        LV_X
    } level_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic                 s_tuser;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    // Model of the array: personality store, held inputs and registers.
    logic [FIELD_W-1:0] pers_value [NUM_OUTPUTS];
    logic [FIELD_W-1:0] pers_unknown [NUM_OUTPUTS];
    logic [FIELD_W-1:0] held_in_value;
    logic [FIELD_W-1:0] held_in_unknown;
    logic               evaluated_seen;
    logic [1:0]         reg_kind;
    logic               reg_plane;
    logic               reg_async;

    pla_out_t pending_outputs [$];

    bit tx_idle_on;
    bit rx_idle_on;
    int error_count;
    int beats_sent;
    int results_checked;
    int settings_used;
    int cycle_count = 0;

    four_state_pla_evaluator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outputs.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Four-state scalar operators with Verilog semantics.
    function automatic level_t lv_and(level_t a, level_t b);
        if (a == LV_0 || b == LV_0)
        begin
            return LV_0;
        end
        return (a == LV_1 && b == LV_1) ? LV_1 : LV_X;
    endfunction

    function automatic level_t lv_or(level_t a, level_t b);
        if (a == LV_1 || b == LV_1)
        begin
            return LV_1;
        end
        return (a == LV_0 && b == LV_0) ? LV_0 : LV_X;
    endfunction

    function automatic level_t lv_not(level_t a);
        if (a == LV_X)
        begin
            return LV_X;
        end
        return (a == LV_0) ? LV_1 : LV_0;
    endfunction

    // Reduce one personality row against the held inputs.
    function automatic level_t reduce_row(int r);
        bit     is_and;
        level_t acc;
        level_t in_lv;
        level_t term;
        is_and = (reg_kind == KIND_AND) || (reg_kind == KIND_NAND);
        acc = is_and ? LV_1 : LV_0;
        for (int p = 0; p < NUM_INPUTS && p < FIELD_W; p++)
        begin
            if (held_in_unknown[p])
            begin
                in_lv = LV_X;
            end
            else
            begin
                in_lv = held_in_value[p] ? LV_1 : LV_0;
            end
            if (reg_plane)
            begin
                // Plane codes: 0 complement, 1 true, x unknown, z skipped.
                if (!pers_unknown[r][p])
                begin
                    term = pers_value[r][p] ? in_lv : lv_not(in_lv);
                end
                else if (pers_value[r][p])
                begin
                    term = LV_X;
                end
                else
                begin
                    continue;
                end
            end
            else
            begin
                // Array codes: only a clean 1 selects the column.
                if (!(pers_value[r][p] && !pers_unknown[r][p]))
                begin
                    continue;
                end
                term = in_lv;
            end
            acc = is_and ? lv_and(acc, term) : lv_or(acc, term);
        end
        if (reg_kind == KIND_NAND || reg_kind == KIND_NOR)
        begin
            acc = lv_not(acc);
        end
        return acc;
    endfunction

    // Output term vector for the current personality and held inputs.
    function automatic pla_out_t pla_terms();
        pla_out_t res;
        level_t   v;
        int       pos;
        res = '0;
        for (int j = 0; j < NUM_OUTPUTS; j++)
        begin
            pos = NUM_OUTPUTS - 1 - j;
            v = reduce_row(j);
            if (pos < FIELD_W)
            begin
                if (v == LV_1)
                begin
                    res.aval[pos] = 1'b1;
                end
                else if (v == LV_X)
                begin
                    res.aval[pos] = 1'b1;
                    res.bval[pos] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Apply an accepted item to the model and queue any result it causes.
    function automatic void absorb_item(pla_item_t it);
        if (it.op == OP_WRITE)
        begin
            if (it.row < NUM_OUTPUTS)
            begin
                pers_value[it.row] = it.row_aval;
                pers_unknown[it.row] = it.row_bval;
                if (reg_async && evaluated_seen)
                begin
                    pending_outputs.insert(pending_outputs.size(), pla_terms());
                end
            end
        end
        else
        begin
            held_in_value = it.in_aval;
            held_in_unknown = it.in_bval;
            evaluated_seen = 1'b1;
            pending_outputs.insert(pending_outputs.size(), pla_terms());
        end
    endfunction

    function automatic pla_item_t row_write(int r, logic [FIELD_W-1:0] a,
                                            logic [FIELD_W-1:0] b);
        pla_item_t it;
        it = '0;
        it.op = OP_WRITE;
        it.row = ROW_FLD_W'(r);
        it.row_aval = a;
        it.row_bval = b;
        return it;
    endfunction

    function automatic pla_item_t evaluation(logic [FIELD_W-1:0] a,
                                             logic [FIELD_W-1:0] b);
        pla_item_t it;
        it = '0;
        it.op = OP_EVAL;
        it.in_aval = a;
        it.in_bval = b;
        return it;
    endfunction

    // Value bits: extremes, uniform, sparse and dense words.
    function automatic logic [FIELD_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return FIELD_W'($urandom);
            4: return FIELD_W'($urandom & $urandom & $urandom);
            default: return FIELD_W'($urandom | $urandom | $urandom);
        endcase
    endfunction

    // Unknown bits: mostly clean, sometimes a few, sometimes many.
    function automatic logic [FIELD_W-1:0] rand_unknown();
        case ($urandom_range(0, 5))
            0, 1, 2: return '0;
            3: return FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
            4: return FIELD_W'($urandom & $urandom & $urandom);
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic pla_item_t rand_item();
        pla_item_t it;
        it.op = ($urandom_range(0, 9) < 6) ? OP_WRITE : OP_EVAL;
        it.row = ROW_FLD_W'($urandom_range(0, NUM_OUTPUTS - 1));
        it.row_aval = rand_value();
        it.row_bval = rand_unknown();
        it.in_aval = rand_value();
        it.in_bval = rand_unknown();
        return it;
    endfunction

    // Mismatch reporting: one line per mismatch, and a count.
    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Send one item as an input beat, with an optional gap before it.
    task automatic send_item(pla_item_t it);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  <= it.op;
        s_tdata  <= {4'b0, it.in_bval, it.in_aval, it.row_bval, it.row_aval, it.row};
        s_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        absorb_item(it);
        beats_sent++;
    endtask

    // Stop sending and wait until the block has drained and gone quiet.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drain, then program all three registers and mirror them in the model.
    task automatic set_config(logic [1:0] kind, logic plane, logic async_on);
        wait_idle();
        write_reg(REG_LOGIC_KIND, kind);
        write_reg(REG_PLANE_FORMAT, CFG_DAT_W'(plane));
        write_reg(REG_ASYNC_MODE, CFG_DAT_W'(async_on));
        reg_kind  = kind;
        reg_plane = plane;
        reg_async = async_on;
        settings_used++;
    endtask

    // Result side: random stall before each beat, taken at the rising edge.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(rst_n && m_tvalid));
        end
    end

    // Compare each result beat with the oldest expected output.
    always @(posedge clk)
    begin : result_check
        pla_out_t got;
        pla_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_outputs.size() == 0)
            begin
                report_mismatch($sformatf("result beat %h with nothing expected", m_tdata));
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (got.aval !== want.aval)
                begin
                    report_mismatch($sformatf("out_aval expected %h got %h",
                                              want.aval, got.aval));
                end
                if (got.bval !== want.bval)
                begin
                    report_mismatch($sformatf("out_bval expected %h got %h",
                                              want.bval, got.bval));
                end
                results_checked++;
            end
        end
    end

    // Field extremes, four-state inputs, async writes before and after the
    // first evaluation, empty rows and x/z personality codes.
    task automatic test_directed_extremes();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_config(KIND_AND, 1'b0, 1'b1);
        send_item(row_write(0, '1, '0));
        send_item(evaluation('0, '0));
        send_item(evaluation('1, '0));
        send_item(evaluation('1, '1));
        send_item(evaluation('0, '1));
        send_item(row_write(NUM_OUTPUTS - 1, '1, '1));
        send_item(row_write(1, '0, '1));
        send_item(row_write(2, 16'h5555, '0));
        send_item(evaluation(16'hAAAA, 16'h00FF));
    endtask

    // Every reduction kind in both personality formats, with sync writes.
    task automatic test_directed_kinds();
        for (int k = 0; k < 4; k++)
        begin
            for (int pf = 0; pf < 2; pf++)
            begin
                set_config(2'(k), 1'(pf), 1'b0);
                send_item(row_write(7, 16'hC3A5, 16'h0FF0));
                send_item(evaluation(16'hF0F0, 16'h0000));
            end
        end
    endtask

    // Random streams over a sweep of settings and idling patterns.
    task automatic test_random_stream();
        logic [1:0] kind;
        logic       plane;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph < 8)
            begin
                kind  = ph[2:1];
                plane = ph[0];
            end
            else
            begin
                kind  = 2'($urandom_range(0, 3));
                plane = 1'($urandom_range(0, 1));
            end
            set_config(kind, plane, (ph % 3) != 2);
            tx_idle_on = ph[0] ^ ph[2];
            rx_idle_on = ph[1];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_item(rand_item());
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        error_count     = 0;
        beats_sent      = 0;
        results_checked = 0;
        settings_used   = 0;
        for (int j = 0; j < NUM_OUTPUTS; j++)
        begin
            pers_value[j]   = '0;
            pers_unknown[j] = '0;
        end
        held_in_value   = '0;
        held_in_unknown = '0;
        evaluated_seen  = 1'b0;
        reg_kind        = KIND_AND;
        reg_plane       = 1'b0;
        reg_async       = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_directed_kinds();
        test_random_stream();
        wait_idle();

        if (pending_outputs.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_outputs.size()));
        end
        $display("Sent %0d row writes and evaluations under %0d register settings,",
                 beats_sent, settings_used);
        $display("checked %0d result beats, %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/fspla_pkg.sv
hdl/fspla_row_reduce.sv
hdl/four_state_pla_evaluator_unit.sv
sim/four_state_pla_evaluator_unit_test.sv
